### rtl/core/pocc_pkg.sv
// ----------------------------------------------------------------------------
// pocc_pkg: shared types and constants for the origin containment check
// Fixed widths, result field positions and the per-edge flag bundles.
// ----------------------------------------------------------------------------
package pocc_pkg;

   localparam int AREA_BITS  = 50;
   localparam int RSP_DATA_W = 8;

   // result bit positions inside rsp_tdata
   localparam int RSP_COUNT_OK_BIT  = 0;
   localparam int RSP_AREA_NZ_BIT   = 1;
   localparam int RSP_CONTAINS_BIT  = 2;
   localparam int RSP_ENVELOPE_BIT  = 3;

   localparam logic [1:0] COUNT_MAX = 2'd3;

   // endpoint geometry of one edge a->b, taken before the multiplies settle
   typedef struct packed {
      logic a_up;    // a.y > 0
      logic b_up;    // b.y > 0
      logic rising;  // b.y > a.y
   } edge_geom_type;

   // outcome of one edge against the origin
   typedef struct packed {
      logic on_edge;   // origin lies on the segment
      logic crossing;  // edge crosses the +x ray
   } edge_flag_type;

endpackage

### rtl/core/pocc_edge_class.sv
// ----------------------------------------------------------------------------
// pocc_edge_class: classify one edge from its registered products
// Forms the cross term, the on-edge test and the ray crossing for one edge.
// ----------------------------------------------------------------------------
module pocc_edge_class #(
   parameter int PROD_W = 32
) (
   input  logic signed [PROD_W-1:0]          p1,
   input  logic signed [PROD_W-1:0]          p2,
   input  logic signed [PROD_W-1:0]          d1,
   input  logic signed [PROD_W-1:0]          d2,
   input  pocc_pkg::edge_geom_type           geom,
   output logic signed [pocc_pkg::AREA_BITS-1:0] term,
   output pocc_pkg::edge_flag_type           flag
);
   import pocc_pkg::*;

   localparam int DIFF_W = PROD_W + 1;

   logic signed [DIFF_W-1:0] cross_val;
   logic signed [DIFF_W-1:0] dot;
   logic                     cross_zero;
   logic                     cross_pos;

   assign cross_val  = DIFF_W'(p1) - DIFF_W'(p2);
   assign dot        = DIFF_W'(d1) + DIFF_W'(d2);
   assign cross_zero = (cross_val == '0);
   assign cross_pos  = !cross_val[DIFF_W-1] && !cross_zero;

   // area wraps modulo 2^AREA_BITS, so extend or truncate the term
   assign term = AREA_BITS'(cross_val);

   assign flag.on_edge  = cross_zero && (dot[DIFF_W-1] || (dot == '0));
   assign flag.crossing = (geom.a_up != geom.b_up) && !cross_zero
                          && (cross_pos == geom.rising);

endmodule

### rtl/core/polygon_origin_containment_check_top.sv
// ----------------------------------------------------------------------------
// polygon_origin_containment_check_top: does a closed polygon hold the origin
// Streams vertices, accumulates twice the area and the crossing parity.
// ----------------------------------------------------------------------------
// Throughput: one vertex per cycle, with no bubble between polygons, while
//   rsp is not stalled. Result path: input register, product register,
//   result register.
// Reset: synchronous; empties all three stages, clears the running area,
//   parity, boundary flag and vertex count. No clearing pass is needed.
// ----------------------------------------------------------------------------
module polygon_origin_containment_check_top #(
   parameter int COORD_WIDTH = 16,
   localparam int REQ_DATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // req_tdata, lowest bit up: vertex_x, vertex_y, zero fill
   input  logic [REQ_DATA_W-1:0]           req_tdata,
   input  logic                            req_tlast,   // last_vertex
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // rsp_tdata, lowest bit up: count_ok, area_nonzero, contains_origin,
   // envelope_ok, zero fill
   output logic [pocc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import pocc_pkg::*;

   localparam int W      = COORD_WIDTH;
   localparam int PROD_W = 2 * COORD_WIDTH;

   // ------------------------------------------------------------------
   // Handshake chain: each stage moves when the one after it has room.
   // ------------------------------------------------------------------
   logic a_valid_ff, b_valid_ff, rsp_valid_ff;
   logic b_last_ff;
   logic out_ready, b_go, b_ready, a_go, a_ready, req_go;

   assign out_ready  = !rsp_valid_ff || rsp_tready;
   // a non-last vertex needs no output slot, so it never waits on rsp
   assign b_go       = b_valid_ff && (!b_last_ff || out_ready);
   assign b_ready    = !b_valid_ff || b_go;
   assign a_go       = a_valid_ff && b_ready;
   assign a_ready    = !a_valid_ff || a_go;
   assign req_go     = req_tvalid && a_ready;
   assign req_tready = a_ready;

   // ------------------------------------------------------------------
   // Stage A: input register
   // ------------------------------------------------------------------
   logic signed [W-1:0] a_x_ff, a_y_ff;
   logic                a_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_go) begin
         a_x_ff    <= req_tdata[W-1:0];
         a_y_ff    <= req_tdata[2*W-1:W];
         a_last_ff <= req_tlast;
      end
   end

   // ------------------------------------------------------------------
   // Vertex bookkeeping: first vertex, prior vertex, saturating count.
   // These hold everything accepted before the vertex now in stage A.
   // ------------------------------------------------------------------
   logic signed [W-1:0] first_x_ff, first_y_ff;
   logic signed [W-1:0] prior_x_ff, prior_y_ff;
   logic [1:0]          seen_ff;
   logic [1:0]          seen_in;
   logic                seen_empty;

   assign seen_empty = (seen_ff == 2'd0);
   assign seen_in    = (seen_ff == COUNT_MAX) ? seen_ff : seen_ff + 2'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 2'd0;
      end else if (a_go) begin
         // restart the count after the closing vertex
         seen_ff <= a_last_ff ? 2'd0 : seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_go) begin
         if (seen_empty) begin
            first_x_ff <= a_x_ff;
            first_y_ff <= a_y_ff;
         end
         prior_x_ff <= a_x_ff;
         prior_y_ff <= a_y_ff;
      end
   end

   // ------------------------------------------------------------------
   // Edge operands: edge 0 runs prior->current, edge 1 closes
   // current->first. On a lone vertex the closing edge is to itself.
   // ------------------------------------------------------------------
   logic signed [W-1:0] close_x, close_y;
   logic signed [W-1:0] ax [2];
   logic signed [W-1:0] ay [2];
   logic signed [W-1:0] bx [2];
   logic signed [W-1:0] by [2];

   assign close_x = seen_empty ? a_x_ff : first_x_ff;
   assign close_y = seen_empty ? a_y_ff : first_y_ff;

   assign ax[0] = prior_x_ff;
   assign ay[0] = prior_y_ff;
   assign bx[0] = a_x_ff;
   assign by[0] = a_y_ff;
   assign ax[1] = a_x_ff;
   assign ay[1] = a_y_ff;
   assign bx[1] = close_x;
   assign by[1] = close_y;

   // ------------------------------------------------------------------
   // Stage B: product register (four multiplies per edge, in parallel)
   // ------------------------------------------------------------------
   logic signed [PROD_W-1:0] b_p1_ff [2];
   logic signed [PROD_W-1:0] b_p2_ff [2];
   logic signed [PROD_W-1:0] b_d1_ff [2];
   logic signed [PROD_W-1:0] b_d2_ff [2];
   edge_geom_type            b_geom_ff [2];
   logic                     b_en0_ff;
   logic                     b_cnt_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_go;
      end
   end

   always_ff @(posedge clock) begin
      if (a_go) begin
         for (int i = 0; i < 2; i++) begin
            b_p1_ff[i]          <= PROD_W'(ax[i]) * PROD_W'(by[i]);
            b_p2_ff[i]          <= PROD_W'(ay[i]) * PROD_W'(bx[i]);
            b_d1_ff[i]          <= PROD_W'(ax[i]) * PROD_W'(bx[i]);
            b_d2_ff[i]          <= PROD_W'(ay[i]) * PROD_W'(by[i]);
            b_geom_ff[i].a_up   <= (ay[i] > 0);
            b_geom_ff[i].b_up   <= (by[i] > 0);
            b_geom_ff[i].rising <= (by[i] > ay[i]);
         end
         b_en0_ff    <= !seen_empty;
         b_last_ff   <= a_last_ff;
         b_cnt_ok_ff <= (seen_in == COUNT_MAX);
      end
   end

   // ------------------------------------------------------------------
   // Edge classification and accumulation
   // ------------------------------------------------------------------
   logic signed [AREA_BITS-1:0] edge_term [2];
   edge_flag_type               edge_flag [2];
   logic                        edge_en   [2];

   assign edge_en[0] = b_en0_ff;
   assign edge_en[1] = b_last_ff;   // closing edge only on the last vertex

   for (genvar g = 0; g < 2; g++) begin : g_edge
      pocc_edge_class #(
         .PROD_W (PROD_W)
      ) u_edge_class (
         .p1   (b_p1_ff[g]),
         .p2   (b_p2_ff[g]),
         .d1   (b_d1_ff[g]),
         .d2   (b_d2_ff[g]),
         .geom (b_geom_ff[g]),
         .term (edge_term[g]),
         .flag (edge_flag[g])
      );
   end

   logic signed [AREA_BITS-1:0] area_ff, area_in;
   logic                        parity_ff, parity_in;
   logic                        bound_ff, bound_in;
   logic signed [AREA_BITS-1:0] term0, term1;

   assign term0     = edge_en[0] ? edge_term[0] : '0;
   assign term1     = edge_en[1] ? edge_term[1] : '0;
   assign area_in   = area_ff + term0 + term1;
   assign parity_in = parity_ff
                      ^ (edge_en[0] && edge_flag[0].crossing)
                      ^ (edge_en[1] && edge_flag[1].crossing);
   assign bound_in  = bound_ff
                      || (edge_en[0] && edge_flag[0].on_edge)
                      || (edge_en[1] && edge_flag[1].on_edge);

   always_ff @(posedge clock) begin
      if (reset) begin
         area_ff   <= '0;
         parity_ff <= 1'b0;
         bound_ff  <= 1'b0;
      end else if (b_go) begin
         if (b_last_ff) begin
            // polygon closed: drop the running sums for the next one
            area_ff   <= '0;
            parity_ff <= 1'b0;
            bound_ff  <= 1'b0;
         end else begin
            area_ff   <= area_in;
            parity_ff <= parity_in;
            bound_ff  <= bound_in;
         end
      end
   end

   // ------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------
   logic                  area_ok, contains;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   assign area_ok  = (area_in != '0);
   assign contains = bound_in || parity_in;

   always_comb begin
      rsp_data_in                   = '0;
      rsp_data_in[RSP_COUNT_OK_BIT] = b_cnt_ok_ff;
      rsp_data_in[RSP_AREA_NZ_BIT]  = area_ok;
      rsp_data_in[RSP_CONTAINS_BIT] = contains;
      rsp_data_in[RSP_ENVELOPE_BIT] = b_cnt_ok_ff && area_ok && contains;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (b_go && b_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (b_go && b_last_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### rtl/core/pocc_checker.sv
// ----------------------------------------------------------------------------
// pocc_checker: port-level checks for the origin containment check
// Watches the top-level ports over time; attached by the bind below.
// ----------------------------------------------------------------------------
module pocc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [pocc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import pocc_pkg::*;

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // overall verdict is the conjunction of the three checks
   a_envelope: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_ENVELOPE_BIT] ==
         (rsp_tdata[RSP_COUNT_OK_BIT] && rsp_tdata[RSP_AREA_NZ_BIT]
          && rsp_tdata[RSP_CONTAINS_BIT]))
      else $error("envelope_ok disagrees with the checks");

   // fill bits above the result fields stay zero
   a_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:RSP_ENVELOPE_BIT+1] == '0)
      else $error("result fill bits not zero");

   // reset empties the pipeline: no result, room for a vertex
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

endmodule

bind polygon_origin_containment_check_top pocc_checker u_pocc_checker (.*);
